// ===== rtl/core/bicubic_image_scaler_defines.svh =====
// ----------------------------------------------------------------------------
// bicubic_image_scaler_defines
// assertion macros for the bicubic scaler
// ----------------------------------------------------------------------------
`ifndef BICUBIC_IMAGE_SCALER_DEFINES_SVH
`define BICUBIC_IMAGE_SCALER_DEFINES_SVH
`ifndef SYNTHESIS
`define BIS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("bis assertion failed");
`define BIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("bis assertion failed");
`else
`define BIS_ASSERT(label, clk, rst_n, prop)
`define BIS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/bis_pkg.sv =====
// ----------------------------------------------------------------------------
// bis_pkg
// shared constants, types and kernel weight function of the bicubic scaler
// ----------------------------------------------------------------------------
package bis_pkg;

    localparam int MAX_SOURCE_WIDTH  = 256;
    localparam int MAX_SOURCE_HEIGHT = 256;
    localparam int WEIGHT_FRAC_BITS  = 14;
    localparam int COL_BITS   = $clog2(MAX_SOURCE_WIDTH);
    localparam int ROW_BITS   = $clog2(MAX_SOURCE_HEIGHT);
    localparam int BANK_BITS  = COL_BITS - 2;
    localparam int BANK_ADDR_BITS = ROW_BITS + BANK_BITS;
    localparam int WEIGHT_BITS = WEIGHT_FRAC_BITS + 3;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_STEP   = 2'd2;
    localparam logic [1:0] REG_COLOR  = 2'd3;

    typedef logic signed [WEIGHT_BITS-1:0] weight_t;

    // read command for the four column banks
    typedef struct packed {
        logic                      rd_en;
        logic [ROW_BITS-1:0]       row;
        logic [COL_BITS-1:0]       col;   // leftmost tap column
    } frame_rd_t;

    typedef struct packed {
        logic                      wr_en;
        logic [ROW_BITS-1:0]       row;
        logic [COL_BITS-1:0]       col;
        logic [23:0]               data;
    } frame_wr_t;

    // kernel weight at distance t (q.12, 0..8192), rounded; t2 is t squared
    function automatic weight_t kernel_weight(input logic [13:0] t, input logic [27:0] t2);
        logic        [41:0] t3;
        logic signed [47:0] c1;
        logic signed [47:0] c2;
        logic signed [47:0] c3;
        logic signed [47:0] k;
        logic signed [47:0] b;
        t3 = t2 * t;
        c1 = {6'd0, t3};
        c2 = {8'd0, t2, 12'd0};
        c3 = {10'd0, t, 24'd0};
        // kernel value carries 37 fraction bits
        if (t <= 14'd4096)
            k = 3*c1 - 5*c2 + (48'sd1 <<< 37);
        else if (t < 14'd8192)
            k = -c1 + 5*c2 - 8*c3 + (48'sd1 <<< 38);
        else
            k = 48'sd0;
        b = k + (48'sd1 <<< 40) + (48'sd1 <<< (36 - WEIGHT_FRAC_BITS));
        b = (b >>> (37 - WEIGHT_FRAC_BITS)) - (48'sd1 <<< (40 - 37 + WEIGHT_FRAC_BITS));
        return weight_t'(b);
    endfunction

endpackage

// ===== rtl/core/bis_frame_store.sv =====
// ----------------------------------------------------------------------------
// bis_frame_store
// source frame in four column banks, one row of four taps per read
// ----------------------------------------------------------------------------
module bis_frame_store
    import bis_pkg::*;
(
    input  logic             clk,
    input  frame_wr_t        wr,
    input  frame_rd_t        rd,
    output logic [4*24-1:0]  rd_data
);

    logic [23:0] bank0_mem [2**BANK_ADDR_BITS];
    logic [23:0] bank1_mem [2**BANK_ADDR_BITS];
    logic [23:0] bank2_mem [2**BANK_ADDR_BITS];
    logic [23:0] bank3_mem [2**BANK_ADDR_BITS];
    logic [23:0] q_reg [4];
    logic [1:0]  sel_reg;
    logic [BANK_ADDR_BITS-1:0] wa;
    logic [BANK_ADDR_BITS-1:0] ra [4];
    logic [COL_BITS-1:0] tcol [4];

    assign wa = {wr.row, wr.col[COL_BITS-1:2]};

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            tcol[i] = rd.col + COL_BITS'(i);
        end
        // bank b holds the tap whose column mod 4 equals b
        for (int b = 0; b < 4; b++)
        begin
            ra[b] = {rd.row, tcol[2'(b - int'(rd.col[1:0]))][COL_BITS-1:2]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.wr_en && wr.col[1:0] == 2'd0) bank0_mem[wa] <= wr.data;
        if (wr.wr_en && wr.col[1:0] == 2'd1) bank1_mem[wa] <= wr.data;
        if (wr.wr_en && wr.col[1:0] == 2'd2) bank2_mem[wa] <= wr.data;
        if (wr.wr_en && wr.col[1:0] == 2'd3) bank3_mem[wa] <= wr.data;
        if (rd.rd_en)
        begin
            q_reg[0] <= bank0_mem[ra[0]];
            q_reg[1] <= bank1_mem[ra[1]];
            q_reg[2] <= bank2_mem[ra[2]];
            q_reg[3] <= bank3_mem[ra[3]];
            sel_reg  <= rd.col[1:0];
        end
    end

    // rotate banks back into tap order
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            rd_data[k*24 +: 24] = q_reg[2'(sel_reg + 2'(k))];
        end
    end

endmodule

// ===== rtl/core/bis_row_filter.sv =====
// ----------------------------------------------------------------------------
// bis_row_filter
// horizontal 4-tap filter of one row, registered, then vertical accumulate
// ----------------------------------------------------------------------------
module bis_row_filter
    import bis_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  logic             row_valid,
    input  logic [4*24-1:0]  row_data,
    input  weight_t          wx [4],
    input  weight_t          wy,
    output logic             acc_done,
    output logic [7:0]       ch [3]
);

    localparam int HSUM_BITS = WEIGHT_BITS + 11;
    localparam int ACC_BITS  = HSUM_BITS + WEIGHT_BITS + 2;

    logic signed [HSUM_BITS-1:0] hsum_reg [3];
    logic signed [HSUM_BITS-1:0] hsum_next [3];
    logic signed [WEIGHT_BITS-1:0] wy_reg;
    logic                        hv_reg;
    logic signed [ACC_BITS-1:0]  acc_reg [3];
    logic [2:0]                  cnt_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            hsum_next[c] = '0;
            for (int k = 0; k < 4; k++)
            begin
                hsum_next[c] = hsum_next[c] + HSUM_BITS'(
                    $signed({1'b0, row_data[k*24 + c*8 +: 8]}) * wx[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hsum_reg <= hsum_next;
        wy_reg   <= wy;
        for (int c = 0; c < 3; c++)
        begin
            if (clear)
                acc_reg[c] <= '0;
            else if (hv_reg)
                acc_reg[c] <= acc_reg[c] + ACC_BITS'(hsum_reg[c] * wy_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hv_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            hv_reg <= row_valid;
            if (clear)
                cnt_reg <= '0;
            else if (hv_reg)
                cnt_reg <= cnt_reg + 3'd1;
        end
    end

    assign acc_done = (cnt_reg == 3'd4);

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (acc_reg[c] < 0)
                ch[c] = 8'd0;
            else if ((acc_reg[c] >>> (2*WEIGHT_FRAC_BITS)) > 255)
                ch[c] = 8'd255;
            else
                ch[c] = 8'(acc_reg[c] >>> (2*WEIGHT_FRAC_BITS));
        end
    end

endmodule

// ===== rtl/core/bicubic_image_scaler.sv =====
// ----------------------------------------------------------------------------
// bicubic_image_scaler
// A write beat stores one pixel. A request beat passes from acceptance to a
// valid result through position decode and weight computation (one tap per
// cycle, distance squared first, then the cubic), four row reads of the
// four-way column-banked frame store (one row per cycle), the filter pipeline
// (store read register, horizontal sum register, accumulator), a final clamp
// and the output register. A request whose position falls outside the usable
// area skips the reads and gives a zero result. One request is in flight at
// a time; the output register lets the next beat enter while a result waits
// to be taken, and a second finished request stalls until it is free. The
// frame store has no reset.
// ----------------------------------------------------------------------------
`include "bicubic_image_scaler_defines.svh"
module bicubic_image_scaler
    import bis_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [11:0] coord_x,
    input  logic [11:0] coord_y,
    input  logic [23:0] pixel_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] dest_x,
    output logic [11:0] dest_y,
    output logic [7:0]  channel_0,
    output logic [7:0]  channel_1,
    output logic [7:0]  channel_2
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_POS  = 5'b00010,
        ST_READ = 5'b00100,
        ST_WAIT = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [8:0]  width_reg, height_reg;
    logic [15:0] step_reg;
    logic        color_reg;
    logic [11:0] cx_reg, cy_reg;
    logic [27:0] px_reg, py_reg;
    logic        pos_zero;
    logic [1:0]  rcnt_reg;
    logic [2:0]  wcnt_reg;
    logic [13:0] tx_tap, ty_tap;
    logic [13:0] tx_reg, ty_reg;
    logic [27:0] tx2_reg, ty2_reg;
    logic        ov_reg;
    logic [11:0] ox_reg, oy_reg;
    logic [7:0]  oc_reg [3];
    weight_t     wx_reg [4];
    weight_t     wy_reg [4];
    logic [15:0] v, w;
    logic [8:0]  wd, ht;
    logic        in_fire, out_free;
    frame_wr_t   wr;
    frame_rd_t   rd;
    logic [4*24-1:0] row_data;
    logic        rv_reg, acc_done;
    logic [7:0]  ch [3];

    assign in_fire  = in_valid && in_ready;
    assign out_free = !ov_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            step_reg   <= 16'd4096;
            color_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[8:0];
                REG_HEIGHT: height_reg <= cfg_data[8:0];
                REG_STEP:   step_reg   <= cfg_data;
                REG_COLOR:  color_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign wr.wr_en = in_fire && opcode == OP_WRITE
                      && coord_x < 12'(MAX_SOURCE_WIDTH) && coord_y < 12'(MAX_SOURCE_HEIGHT);
    assign wr.row  = coord_y[ROW_BITS-1:0];
    assign wr.col  = coord_x[COL_BITS-1:0];
    assign wr.data = pixel_data;

    assign wd = (width_reg  > 9'(MAX_SOURCE_WIDTH))  ? 9'(MAX_SOURCE_WIDTH)  : width_reg;
    assign ht = (height_reg > 9'(MAX_SOURCE_HEIGHT)) ? 9'(MAX_SOURCE_HEIGHT) : height_reg;
    assign v  = px_reg[27:12];
    assign w  = py_reg[27:12];

    assign rd.rd_en = (state_reg == ST_READ);
    assign rd.row   = ROW_BITS'(w + 16'(rcnt_reg) - 16'd1);
    assign rd.col   = COL_BITS'(v - 16'd1);

    bis_frame_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (row_data)
    );

    bis_row_filter u_filter (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (state_reg == ST_POS),
        .row_valid (rv_reg),
        .row_data  (row_data),
        .wx        (wx_reg),
        .wy        (wy_reg[rcnt_reg - 2'd1]),
        .acc_done  (acc_done),
        .ch        (ch)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_fire && opcode == OP_REQUEST) state_next = ST_POS;
            ST_POS:
            begin
                priority if (pos_zero)
                    state_next = ST_DONE;
                else if (wcnt_reg == 3'd4)
                    state_next = ST_READ;
            end
            ST_READ: if (rcnt_reg == 2'd3) state_next = ST_WAIT;
            ST_WAIT: if (acc_done) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // tap distance of the tap picked by the weight counter
    always_comb
    begin
        unique case (wcnt_reg[1:0])
            2'd0:
            begin
                tx_tap = 14'd4096 + {2'd0, px_reg[11:0]};
                ty_tap = 14'd4096 + {2'd0, py_reg[11:0]};
            end
            2'd1:
            begin
                tx_tap = {2'd0, px_reg[11:0]};
                ty_tap = {2'd0, py_reg[11:0]};
            end
            2'd2:
            begin
                tx_tap = 14'd4096 - {2'd0, px_reg[11:0]};
                ty_tap = 14'd4096 - {2'd0, py_reg[11:0]};
            end
            2'd3:
            begin
                tx_tap = 14'd8192 - {2'd0, px_reg[11:0]};
                ty_tap = 14'd8192 - {2'd0, py_reg[11:0]};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cx_reg <= coord_x;
            cy_reg <= coord_y;
            px_reg <= coord_x * step_reg;
            py_reg <= coord_y * step_reg;
        end
        if (state_reg == ST_POS)
        begin
            // square the distance of tap n, finish the weight of tap n-1
            tx_reg  <= tx_tap;
            ty_reg  <= ty_tap;
            tx2_reg <= tx_tap * tx_tap;
            ty2_reg <= ty_tap * ty_tap;
            if (wcnt_reg != 3'd0)
            begin
                wx_reg[wcnt_reg[1:0] - 2'd1] <= kernel_weight(tx_reg, tx2_reg);
                wy_reg[wcnt_reg[1:0] - 2'd1] <= kernel_weight(ty_reg, ty2_reg);
            end
        end
        if (state_reg == ST_DONE && out_free)
        begin
            ox_reg    <= cx_reg;
            oy_reg    <= cy_reg;
            oc_reg[0] <= pos_zero ? 8'd0 : ch[0];
            oc_reg[1] <= (pos_zero || !color_reg) ? 8'd0 : ch[1];
            oc_reg[2] <= (pos_zero || !color_reg) ? 8'd0 : ch[2];
        end
    end

    always_comb
    begin
        pos_zero = px_reg == '0 || py_reg == '0
                   || px_reg >= {7'd0, wd, 12'd0} || py_reg >= {7'd0, ht, 12'd0}
                   || v < 16'd2 || v + 16'd2 >= {7'd0, wd}
                   || w < 16'd2 || w + 16'd2 >= {7'd0, ht};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rcnt_reg  <= '0;
            wcnt_reg  <= '0;
            rv_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= (state_reg == ST_READ);
            if (state_reg == ST_READ)
                rcnt_reg <= rcnt_reg + 2'd1;
            else if (state_reg != ST_WAIT)
                rcnt_reg <= '0;
            if (state_reg == ST_POS)
                wcnt_reg <= wcnt_reg + 3'd1;
            else
                wcnt_reg <= '0;
            if (state_reg == ST_DONE && out_free)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    assign out_valid = ov_reg;
    assign dest_x    = ox_reg;
    assign dest_y    = oy_reg;
    assign channel_0 = oc_reg[0];
    assign channel_1 = oc_reg[1];
    assign channel_2 = oc_reg[2];

    `BIS_ASSERT(a_ready_idle, clk, rst_n, in_ready |-> state_reg == ST_IDLE)
    `BIS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `BIS_ASSERT_NEXT(a_read_len, clk, rst_n, state_reg == ST_READ && rcnt_reg == 2'd3, state_reg == ST_WAIT)
    `BIS_ASSERT(a_pos_len, clk, rst_n, state_reg == ST_POS |-> wcnt_reg <= 3'd4)

endmodule

// ===== verif/tb_bicubic_image_scaler.sv =====
// ----------------------------------------------------------------------------
// tb_bicubic_image_scaler
// Self-checking bench for the bicubic scaler. A scoreboard keeps its own copy
// of the frame store and registers and computes the expected pixel of each
// request beat with the Keys kernel. The bench runs directed edge cases and
// then random phases across several register settings, with bursty input and
// receiver stalls.
// ----------------------------------------------------------------------------
module tb_bicubic_image_scaler;
    import bis_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [11:0] x;
        logic [11:0] y;
        logic [7:0]  c0;
        logic [7:0]  c1;
        logic [7:0]  c2;
    } pixel_out_t;

    class scaler_scoreboard;
        logic [23:0] frame [MAX_SOURCE_WIDTH*MAX_SOURCE_HEIGHT];
        bit          written [MAX_SOURCE_WIDTH*MAX_SOURCE_HEIGHT];
        int unsigned width_reg;
        int unsigned height_reg;
        int unsigned step_reg;
        bit          color_reg;
        pixel_out_t  pending_px [$];
        int          errors;

        function void reset_regs();
            width_reg  = 256;
            height_reg = 256;
            step_reg   = 4096;
            color_reg  = 1'b1;
            errors     = 0;
        endfunction

        function void set_reg(logic [1:0] idx, int unsigned val);
            case (idx)
                REG_WIDTH:  width_reg  = val & 9'h1ff;
                REG_HEIGHT: height_reg = val & 9'h1ff;
                REG_STEP:   step_reg   = val & 16'hffff;
                REG_COLOR:  color_reg  = val[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_px.size();
        endfunction

        // keys kernel, a = -0.5, rounded to the weight fraction
        function longint keys_weight(longint t);
            longint u;
            longint k;
            u = 4096;
            if (t <= u)
                k = 3*t*t*t - 5*t*t*u + 2*u*u*u;
            else if (t < 2*u)
                k = -t*t*t + 5*t*t*u - 8*t*u*u + 4*u*u*u;
            else
                k = 0;
            // k carries 37 fraction bits
            return (k + (longint'(1) <<< (36 - WEIGHT_FRAC_BITS))) >>> (37 - WEIGHT_FRAC_BITS);
        endfunction

        // true when the request lands inside the usable area
        function bit in_window(logic [11:0] cx, logic [11:0] cy, output int v, output int w,
                               output int fx, output int fy);
            longint wd;
            longint ht;
            longint px;
            longint py;
            wd = (width_reg < MAX_SOURCE_WIDTH) ? width_reg : MAX_SOURCE_WIDTH;
            ht = (height_reg < MAX_SOURCE_HEIGHT) ? height_reg : MAX_SOURCE_HEIGHT;
            px = longint'(cx) * step_reg;
            py = longint'(cy) * step_reg;
            v  = int'(px >> 12);
            w  = int'(py >> 12);
            fx = int'(px & 4095);
            fy = int'(py & 4095);
            return px != 0 && py != 0 && px < wd*4096 && py < ht*4096 &&
                   v >= 2 && v + 2 < wd && w >= 2 && w + 2 < ht;
        endfunction

        function void note_input(logic op, logic [11:0] cx, logic [11:0] cy, logic [23:0] d);
            int v, w, fx, fy;
            longint wx [4];
            longint wy [4];
            longint acc;
            logic [7:0] ch [3];
            logic [7:0] pix;
            pixel_out_t e;
            if (op == OP_WRITE) begin
                if (cx < MAX_SOURCE_WIDTH && cy < MAX_SOURCE_HEIGHT) begin
                    frame[cy*MAX_SOURCE_WIDTH + cx]   = d;
                    written[cy*MAX_SOURCE_WIDTH + cx] = 1'b1;
                end
                return;
            end
            ch = '{8'd0, 8'd0, 8'd0};
            if (in_window(cx, cy, v, w, fx, fy)) begin
                wx = '{keys_weight(4096 + fx), keys_weight(fx),
                       keys_weight(4096 - fx), keys_weight(8192 - fx)};
                wy = '{keys_weight(4096 + fy), keys_weight(fy),
                       keys_weight(4096 - fy), keys_weight(8192 - fy)};
                for (int c = 0; c < (color_reg ? 3 : 1); c++) begin
                    acc = 0;
                    for (int r = 0; r < 4; r++)
                        for (int k = 0; k < 4; k++) begin
                            pix = 8'(frame[(w - 1 + r)*MAX_SOURCE_WIDTH + v - 1 + k] >> (8*c));
                            acc += longint'(pix) * wy[r] * wx[k];
                        end
                    if (acc < 0)
                        ch[c] = 8'd0;
                    else
                        ch[c] = ((acc >>> (2*WEIGHT_FRAC_BITS)) > 255) ? 8'd255
                              : 8'(acc >>> (2*WEIGHT_FRAC_BITS));
                end
            end
            e.x = cx; e.y = cy; e.c0 = ch[0]; e.c1 = ch[1]; e.c2 = ch[2];
            pending_px.push_back(e);
        endfunction

        function void check_result(logic [11:0] x, logic [11:0] y,
                                   logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
            pixel_out_t e;
            if (pending_px.size() == 0) begin
                $error("result beat with no pending request: x=%0d y=%0d", x, y);
                errors++;
                return;
            end
            e = pending_px.pop_front();
            if (x !== e.x) begin
                $error("dest_x expected %0d actual %0d", e.x, x); errors++;
            end
            if (y !== e.y) begin
                $error("dest_y expected %0d actual %0d", e.y, y); errors++;
            end
            if (c0 !== e.c0) begin
                $error("channel_0 expected %0d actual %0d", e.c0, c0); errors++;
            end
            if (c1 !== e.c1) begin
                $error("channel_1 expected %0d actual %0d", e.c1, c1); errors++;
            end
            if (c2 !== e.c2) begin
                $error("channel_2 expected %0d actual %0d", e.c2, c2); errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        opcode;
    logic [11:0] coord_x;
    logic [11:0] coord_y;
    logic [23:0] pixel_data;
    logic        out_valid;
    logic        out_ready;
    logic [11:0] dest_x;
    logic [11:0] dest_y;
    logic [7:0]  channel_0;
    logic [7:0]  channel_1;
    logic [7:0]  channel_2;

    scaler_scoreboard sb;
    int  burst_left;
    int  cycle_count;
    bit  hold_request;
    int  hold_left;
    int  stall_mode;
    int  stall_phase;

    bicubic_image_scaler dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .pixel_data (pixel_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .dest_x     (dest_x),
        .dest_y     (dest_y),
        .channel_0  (channel_0),
        .channel_1  (channel_1),
        .channel_2  (channel_2)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("bicubic_image_scaler test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(dest_x, dest_y, channel_0, channel_1, channel_2);
    end

    // receiver: stall pattern re-picked at random over time, plus a long hold on demand
    always @(negedge clk)
    begin
        stall_phase++;
        if (stall_phase % 50 == 0)
            stall_mode = $urandom_range(0, 3);
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = 300;
            out_ready   <= 1'b0;
        end else begin
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= $urandom_range(0, 1);
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= (stall_phase % 3 == 0);
            endcase
        end
    end

    task automatic send_item(logic op, logic [11:0] cx, logic [11:0] cy, logic [23:0] d);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        in_valid   <= 1'b1;
        opcode     <= op;
        coord_x    <= cx;
        coord_y    <= cy;
        pixel_data <= d;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_input(op, cx, cy, d);
    endtask

    // byte values biased to the extremes so clamping and negative sums show up
    function automatic logic [23:0] pick_pixel();
        logic [23:0] d;
        for (int b = 0; b < 3; b++)
            case ($urandom_range(0, 3))
                0: d[8*b +: 8] = 8'h00;
                1: d[8*b +: 8] = 8'hff;
                default: d[8*b +: 8] = 8'($urandom_range(0, 255));
            endcase
        return d;
    endfunction

    // for a request inside the usable area, fills any unwritten tap of the 4x4 window; then sends the request
    task automatic send_request(logic [11:0] cx, logic [11:0] cy);
        int v, w, fx, fy;
        if (sb.in_window(cx, cy, v, w, fx, fy))
            for (int r = w - 1; r <= w + 2; r++)
                for (int c = v - 1; c <= v + 2; c++)
                    if (!sb.written[r*MAX_SOURCE_WIDTH + c])
                        send_item(OP_WRITE, 12'(c), 12'(r), pick_pixel());
        send_item(OP_REQUEST, cx, cy, 24'($urandom));
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic configure(int unsigned wd, int unsigned ht, int unsigned st, bit col);
        int unsigned vals [4];
        vals = '{wd, ht, st, col};
        drain();
        repeat (20) @(negedge clk);
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data  <= 16'(vals[i]);
            sb.set_reg(2'(i), vals[i]);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // most windows stay in a small corner patch so filled taps get reused
    function automatic logic [11:0] pick_coord(int unsigned dim);
        longint lim;
        if (sb.step_reg == 0 || $urandom_range(0, 9) == 0)
            return 12'($urandom);
        lim = (longint'((dim < 16) ? dim : 16) * 4096) / sb.step_reg + 1;
        if (lim > 4095)
            lim = 4095;
        return 12'($urandom_range(0, int'(lim)));
    endfunction

    task automatic random_phase(int n, bit with_hold);
        int wd, ht;
        wd = (sb.width_reg < MAX_SOURCE_WIDTH) ? sb.width_reg : MAX_SOURCE_WIDTH;
        ht = (sb.height_reg < MAX_SOURCE_HEIGHT) ? sb.height_reg : MAX_SOURCE_HEIGHT;
        for (int i = 0; i < n; i++) begin
            if (with_hold && i == n/2)
                hold_request = 1'b1;
            if (i == n/3)
                drain();
            if ($urandom_range(0, 99) < 15)
                send_item(OP_WRITE,
                          $urandom_range(0, 1) ? 12'($urandom_range(0, 255)) : 12'($urandom),
                          $urandom_range(0, 1) ? 12'($urandom_range(0, 255)) : 12'($urandom),
                          24'($urandom));
            else
                send_request(pick_coord(wd), pick_coord(ht));
        end
    endtask

    initial
    begin
        sb = new();
        sb.reset_regs();
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_WIDTH;
        cfg_data     = '0;
        in_valid     = 1'b0;
        opcode       = OP_WRITE;
        coord_x      = '0;
        coord_y      = '0;
        pixel_data   = '0;
        out_ready    = 1'b0;
        burst_left   = 0;
        cycle_count  = 0;
        hold_request = 1'b0;
        hold_left    = 0;
        stall_mode   = 0;
        stall_phase  = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // directed: edges, border, outside writes, data extremes
        send_item(OP_WRITE, 12'd4095, 12'd4095, 24'hffffff);
        send_item(OP_WRITE, 12'd4095, 12'd3, 24'h123456);
        send_item(OP_WRITE, 12'd5, 12'd300, 24'h654321);
        send_item(OP_WRITE, 12'd9, 12'd10, 24'hffffff);
        send_item(OP_WRITE, 12'd10, 12'd10, 24'h000000);
        send_request(12'd0, 12'd0);
        send_request(12'd0, 12'd50);
        send_request(12'd50, 12'd0);
        send_request(12'd256, 12'd10);
        send_request(12'd4095, 12'd4095);
        send_request(12'd255, 12'd255);
        send_request(12'd1, 12'd10);
        send_request(12'd10, 12'd1);
        send_request(12'd2, 12'd2);
        send_request(12'd253, 12'd253);
        send_request(12'd10, 12'd10);
        configure(256, 256, 2048 + 1000, 1);
        send_request(12'd20, 12'd20);
        send_request(12'd21, 12'd30);
        configure(256, 256, 4096 + 2047, 0);
        send_request(12'd7, 12'd9);
        send_request(12'd40, 12'd33);

        configure(256, 256, 4096, 1);
        random_phase(40, 1'b1);
        configure(511, 511, 2048, 0);
        random_phase(40, 1'b0);
        configure(4, 4, 65535, 1);
        random_phase(20, 1'b0);
        configure(16, 12, 1, 1);
        random_phase(20, 1'b0);
        configure(20, 20, 0, 0);
        random_phase(20, 1'b0);
        configure(40, 30, 3000, 1);
        random_phase(60, 1'b1);
        configure(64, 64, 1500, 0);
        random_phase(50, 1'b0);
        configure(256, 200, 65535, 1);
        random_phase(30, 1'b0);
        configure(24, 256, 5461, 1);
        random_phase(50, 1'b1);

        drain();
        repeat (30) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("bicubic_image_scaler test passed");
        else
            $display("bicubic_image_scaler test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/bis_pkg.sv
rtl/core/bis_frame_store.sv
rtl/core/bis_row_filter.sv
rtl/core/bicubic_image_scaler.sv
verif/tb_bicubic_image_scaler.sv
